// ===== rtl/tse_pkg.sv =====
// Shared constants, control word type and microprogram for the Taylor series core.
// Used by taylor_series_evaluator_core; depends on nothing else.
`default_nettype none
package tse_pkg;

  localparam int MAX_TERMS_DEF = 16;

  localparam int X_W      = 16;
  localparam int XMAG_W   = 16;
  localparam int TERM_W   = 47;
  localparam int LO_W     = 24;
  localparam int HI_W     = TERM_W - LO_W;
  localparam int PROD_W   = TERM_W + XMAG_W;
  localparam int X_FRAC   = 12;
  localparam int DIV_RADIX_BITS = 4;
  localparam int DVD_W    = ((PROD_W - X_FRAC + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS)
                            * DIV_RADIX_BITS;
  localparam int DIV_ITERS = DVD_W / DIV_RADIX_BITS;
  localparam int DCNT_W   = $clog2(DIV_ITERS);
  localparam int SUM_W    = 64;
  localparam int FRAC_BITS = 32;
  localparam int RES_W    = 32;
  localparam int MR_W     = SUM_W - 16;

  localparam logic [TERM_W-1:0] TERM_MAX = {TERM_W{1'b1}};

  localparam logic [1:0] CMD_EXP = 2'd0;
  localparam logic [1:0] CMD_SIN = 2'd1;
  localparam logic [1:0] CMD_COS = 2'd2;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_TEST  = 4'd1;
  localparam step_t S_ACC   = 4'd2;
  localparam step_t S_MLO   = 4'd3;
  localparam step_t S_MHI   = 4'd4;
  localparam step_t S_DLD   = 4'd5;
  localparam step_t S_DIV   = 4'd6;
  localparam step_t S_DEND  = 4'd7;
  localparam step_t S_JMP   = 4'd8;
  localparam step_t S_FINAL = 4'd9;
  localparam step_t S_RET   = 4'd10;

  typedef logic [2:0] op_t;

  localparam op_t OP_NOP  = 3'd0;
  localparam op_t OP_LOAD = 3'd1;
  localparam op_t OP_ACC  = 3'd2;
  localparam op_t OP_MLO  = 3'd3;
  localparam op_t OP_MHI  = 3'd4;
  localparam op_t OP_DLD  = 3'd5;
  localparam op_t OP_DIV  = 3'd6;
  localparam op_t OP_DEND = 3'd7;

  typedef logic [2:0] cond_t;

  localparam cond_t C_NEVER     = 3'd0;
  localparam cond_t C_ALWAYS    = 3'd1;
  localparam cond_t C_NO_IN     = 3'd2;
  localparam cond_t C_ZERO      = 3'd3;
  localparam cond_t C_LAST      = 3'd4;
  localparam cond_t C_DIV_MORE  = 3'd5;
  localparam cond_t C_TERM_DONE = 3'd6;
  localparam cond_t C_OUT_BUSY  = 3'd7;

  typedef struct packed {
    op_t   op;
    logic  fin;
    cond_t cond;
    step_t target;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{op: OP_NOP, fin: 1'b0, cond: C_ALWAYS, target: S_IDLE};
    unique case (step)
      S_IDLE:  w = '{op: OP_LOAD, fin: 1'b0, cond: C_NO_IN,     target: S_IDLE};
      S_TEST:  w = '{op: OP_NOP,  fin: 1'b0, cond: C_ZERO,      target: S_FINAL};
      S_ACC:   w = '{op: OP_ACC,  fin: 1'b0, cond: C_LAST,      target: S_FINAL};
      S_MLO:   w = '{op: OP_MLO,  fin: 1'b0, cond: C_NEVER,     target: S_IDLE};
      S_MHI:   w = '{op: OP_MHI,  fin: 1'b0, cond: C_NEVER,     target: S_IDLE};
      S_DLD:   w = '{op: OP_DLD,  fin: 1'b0, cond: C_NEVER,     target: S_IDLE};
      S_DIV:   w = '{op: OP_DIV,  fin: 1'b0, cond: C_DIV_MORE,  target: S_DIV};
      S_DEND:  w = '{op: OP_DEND, fin: 1'b0, cond: C_TERM_DONE, target: S_ACC};
      S_JMP:   w = '{op: OP_NOP,  fin: 1'b0, cond: C_ALWAYS,    target: S_MLO};
      S_FINAL: w = '{op: OP_NOP,  fin: 1'b1, cond: C_OUT_BUSY,  target: S_FINAL};
      S_RET:   w = '{op: OP_NOP,  fin: 1'b0, cond: C_ALWAYS,    target: S_IDLE};
      default: w = '{op: OP_NOP,  fin: 1'b0, cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/taylor_series_evaluator_core.sv =====
// Taylor series core for e^x, sin(x) and cos(x): microcoded sequencer and datapath.
// Depends on tse_pkg for constants, control word type and the microprogram.
//
// Usage:
//   Slave channel s_axis carries one request per beat: tuser holds the function
//   select (0 exp, 1 sine, 2 cosine), tdata holds x in Q3.12 and the term count.
//   Master channel m_axis returns one beat per request: tdata holds the Q15.16
//   sum, tuser the overflow flag.
//   One request is worked on at a time; s_axis_tready is high only while the
//   sequencer sits in its idle step. Each term after the first is built by a
//   split multiply over the low and high halves of the term and a divide by
//   the power index that retires four quotient bits per cycle; sine and
//   cosine make two such updates per term. A zero term count goes straight
//   to the final step. A new request is taken only once the last result has
//   left the final step and the sequencer is back in its idle step.
//   A finished result waits in the output register; if the receiver stalls,
//   the sequencer holds in its final step until the register frees.
//   Reset returns the sequencer to idle and empties the output register.
`default_nettype none
module taylor_series_evaluator_core #(
  parameter int MAX_TERMS = tse_pkg::MAX_TERMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [15:0] x_value, [20:16] term_count
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // [31:0] result
  output logic [0:0]       m_axis_tuser   // [0] overflow
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int KW = $clog2(2 * MAX_TERMS);
  localparam int TW = tse_pkg::TERM_W;
  localparam int PW = tse_pkg::PROD_W;
  localparam int DW = tse_pkg::DVD_W;
  localparam int SW = tse_pkg::SUM_W;
  localparam int MW = tse_pkg::MR_W;
  localparam int LW = tse_pkg::LO_W;
  localparam int HW = tse_pkg::HI_W;
  localparam int XW = tse_pkg::XMAG_W;
  localparam int NB = tse_pkg::DIV_RADIX_BITS;
  localparam int DCW = tse_pkg::DCNT_W;

  tse_pkg::step_t step_q, step_d;
  tse_pkg::ctrl_t cw;

  logic [1:0]                 cmd_q;
  logic                       xneg_q;
  logic [XW-1:0]              xmag_q;
  logic [CW-1:0]              n_q, c_q;
  logic [KW-1:0]              k_q;
  logic                       half_q;
  logic                       tsign_q;
  logic [TW-1:0]              tmag_q;
  logic [PW-1:0]              prod_q;
  logic [DW-1:0]              dvd_q, dvd_d;
  logic [KW-1:0]              rem_q, rem_d;
  logic [DCW-1:0]             dcnt_q;
  logic [SW-1:0]              sum_q;
  logic                       ovf_q;
  logic                       out_valid_q;
  logic [31:0]                out_data_q;
  logic                       out_ovf_q;

  logic              accept;
  logic              out_free;
  logic              jump;
  logic [XW-1:0]     in_xmag;
  logic              in_xneg;
  logic [CW-1:0]     in_n;
  logic [KW:0]       r;
  logic [PW-1:0]     rnd_sum;
  logic [LW+XW-1:0]  mlo_p;
  logic [HW+XW-1:0]  mhi_p;
  logic              subtract;
  logic [SW-1:0]     tval;
  logic [SW-1:0]     ms;
  logic [MW-1:0]     mr;
  logic              fin_sat;
  logic [31:0]       fin_res;
  logic              q_sat;
  logic [TW-1:0]     q_mag;

  assign cw            = tse_pkg::ucode(step_q);
  assign s_axis_tready = (step_q == tse_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_xneg = s_axis_tdata[15];
  assign in_xmag = in_xneg ? XW'(-s_axis_tdata[15:0]) : s_axis_tdata[15:0];

  always_comb begin
    if (s_axis_tuser > tse_pkg::CMD_COS) begin
      in_n = '0;
    end else if (int'(s_axis_tdata[20:16]) > MAX_TERMS) begin
      in_n = CW'(MAX_TERMS);
    end else begin
      in_n = CW'(s_axis_tdata[20:16]);
    end
  end

  always_comb begin
    unique case (cw.cond)
      tse_pkg::C_NEVER:     jump = 1'b0;
      tse_pkg::C_ALWAYS:    jump = 1'b1;
      tse_pkg::C_NO_IN:     jump = !accept;
      tse_pkg::C_ZERO:      jump = (n_q == '0);
      tse_pkg::C_LAST:      jump = (c_q == n_q);
      tse_pkg::C_DIV_MORE:  jump = (dcnt_q != DCW'(tse_pkg::DIV_ITERS - 1));
      tse_pkg::C_TERM_DONE: jump = (cmd_q == tse_pkg::CMD_EXP) || half_q;
      tse_pkg::C_OUT_BUSY:  jump = !out_free;
      default:              jump = 1'b1;
    endcase
    step_d = jump ? cw.target : tse_pkg::step_t'(step_q + 1'b1);
  end

  assign mlo_p   = tmag_q[LW-1:0] * xmag_q;
  assign mhi_p   = tmag_q[TW-1:LW] * xmag_q;
  assign rnd_sum = prod_q + (PW'(k_q) << (tse_pkg::X_FRAC - 1));

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    r     = '0;
    for (int b = 0; b < NB; b++) begin
      r     = {rem_d, dvd_d[DW-1]};
      dvd_d = {dvd_d[DW-2:0], 1'b0};
      if (r >= {1'b0, k_q}) begin
        rem_d    = KW'(r - {1'b0, k_q});
        dvd_d[0] = 1'b1;
      end else begin
        rem_d = KW'(r);
      end
    end
  end

  assign q_sat = (dvd_q > DW'(tse_pkg::TERM_MAX));
  assign q_mag = q_sat ? tse_pkg::TERM_MAX : TW'(dvd_q);

  assign subtract = (cmd_q != tse_pkg::CMD_EXP) && !c_q[0];
  assign tval     = SW'(tmag_q);

  assign ms      = sum_q[SW-1] ? SW'(-sum_q) : sum_q;
  assign mr      = MW'((ms + (SW'(1) << 15)) >> 16);
  always_comb begin
    fin_sat = 1'b0;
    fin_res = 32'(mr);
    if (sum_q[SW-1]) begin
      if (mr > (MW'(1) << 31)) begin
        fin_sat = 1'b1;
        fin_res = 32'h8000_0000;
      end else begin
        fin_res = 32'(-mr);
      end
    end else if (mr > MW'(32'h7FFF_FFFF)) begin
      fin_sat = 1'b1;
      fin_res = 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= tse_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cw.fin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cw.fin && out_free) begin
      out_data_q <= fin_res;
      out_ovf_q  <= ovf_q || fin_sat;
    end
    case (cw.op)
      tse_pkg::OP_LOAD: begin
        if (accept) begin
          cmd_q   <= s_axis_tuser;
          xneg_q  <= in_xneg;
          xmag_q  <= in_xmag;
          n_q     <= in_n;
          c_q     <= CW'(1);
          sum_q   <= '0;
          ovf_q   <= 1'b0;
          half_q  <= 1'b0;
          if (s_axis_tuser == tse_pkg::CMD_SIN) begin
            tsign_q <= in_xneg;
            tmag_q  <= TW'(in_xmag) << (tse_pkg::FRAC_BITS - tse_pkg::X_FRAC);
            k_q     <= KW'(1);
          end else begin
            tsign_q <= 1'b0;
            tmag_q  <= TW'(1) << tse_pkg::FRAC_BITS;
            k_q     <= '0;
          end
        end
      end
      tse_pkg::OP_ACC: begin
        sum_q <= (tsign_q ^ subtract) ? sum_q - tval : sum_q + tval;
        c_q   <= CW'(c_q + 1'b1);
      end
      tse_pkg::OP_MLO: begin
        prod_q <= PW'(mlo_p);
        k_q    <= KW'(k_q + 1'b1);
      end
      tse_pkg::OP_MHI: begin
        prod_q <= prod_q + (PW'(mhi_p) << LW);
      end
      tse_pkg::OP_DLD: begin
        dvd_q  <= DW'(rnd_sum >> tse_pkg::X_FRAC);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      tse_pkg::OP_DIV: begin
        dvd_q  <= dvd_d;
        rem_q  <= rem_d;
        dcnt_q <= DCW'(dcnt_q + 1'b1);
      end
      tse_pkg::OP_DEND: begin
        tmag_q  <= q_mag;
        tsign_q <= (tsign_q ^ xneg_q) && (q_mag != '0);
        ovf_q   <= ovf_q || q_sat;
        half_q  <= !half_q && (cmd_q != tse_pkg::CMD_EXP);
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule
`default_nettype wire
